// ===== src/htwd_pkg.sv =====
// Shared types and constants for the Huffman tree-walk decoder.
`default_nettype none

package htwd_pkg;

  localparam int MaxNodes    = 512;
  localparam int MemAddrW    = $clog2(MaxNodes);
  localparam int NodeIdxW    = 9;
  localparam int SymW        = 8;
  localparam int ByteW       = 8;
  localparam int BitsPerByte = 8;
  localparam int BitCntW     = $clog2(BitsPerByte + 1);
  localparam int OpW         = 2;
  localparam int InDataW     = 48;
  localparam int OutDataW    = 8;
  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int QueueCntW   = $clog2(QueueDepth + 1);

  // operation codes carried on the slave tuser
  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_CHECK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic                leaf;
    logic [NodeIdxW-1:0] left;
    logic [NodeIdxW-1:0] right;
    logic [SymW-1:0]     sym;
  } node_t;

  typedef struct packed {
    op_e                 kind;
    logic [NodeIdxW-1:0] idx;
    node_t               node;
    logic [ByteW-1:0]    data;
  } item_t;

endpackage

`default_nettype wire

// ===== src/htwd_front.sv =====
// Front end: takes slave beats, unpacks the fields and drops unused operations.
`default_nettype none

module htwd_front (
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [htwd_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  wire logic [htwd_pkg::OpW-1:0]      s_axis_tuser_i,
  input  wire logic                          q_ready_i,
  output logic                               q_push_o,
  output htwd_pkg::item_t                    q_item_o
);

  logic beat;

  assign s_axis_tready_o = q_ready_i;
  assign beat            = s_axis_tvalid_i & q_ready_i;

  always_comb begin
    q_item_o.kind       = htwd_pkg::op_e'(s_axis_tuser_i);
    q_item_o.idx        = s_axis_tdata_i[8:0];
    q_item_o.node.leaf  = s_axis_tdata_i[9];
    q_item_o.node.left  = s_axis_tdata_i[18:10];
    q_item_o.node.right = s_axis_tdata_i[27:19];
    q_item_o.node.sym   = s_axis_tdata_i[35:28];
    q_item_o.data       = s_axis_tdata_i[43:36];
    q_push_o            = 1'b0;
    case (s_axis_tuser_i)
      htwd_pkg::OP_WRITE,
      htwd_pkg::OP_DECODE,
      htwd_pkg::OP_RESTART: q_push_o = beat;
      default:              q_push_o = 1'b0; // drop the unused code
    endcase
  end

endmodule

`default_nettype wire

// ===== src/htwd_queue.sv =====
// Small FIFO of classified items between front end and walker.
`default_nettype none

module htwd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire htwd_pkg::item_t item_i,
  output logic                 ready_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output htwd_pkg::item_t      item_o
);

  htwd_pkg::item_t                    slot_q [htwd_pkg::QueueDepth];
  logic [htwd_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [htwd_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [htwd_pkg::QueueCntW-1:0]     cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign ready_o = cnt_q != htwd_pkg::QueueCntW'(htwd_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/htwd_back.sv =====
// Walker: node table, bit-serial tree walk and the result register.
`default_nettype none

module htwd_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  wire htwd_pkg::item_t                q_item_i,
  output logic                                q_pop_o,
  input  wire logic [htwd_pkg::NodeIdxW-1:0]  root_index_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [htwd_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  htwd_pkg::node_t                  mem [htwd_pkg::MaxNodes];
  htwd_pkg::node_t                  rd_data_q;
  logic                             rd_ok_q;

  htwd_pkg::state_e                 state_q, state_d;
  logic [htwd_pkg::NodeIdxW-1:0]    pos_q, pos_d;
  logic [htwd_pkg::ByteW-1:0]       byte_q, byte_d;
  logic [htwd_pkg::BitCntW-1:0]     bits_q, bits_d;
  logic                             pend_vld_q, pend_vld_d;
  logic [htwd_pkg::SymW-1:0]        pend_sym_q, pend_sym_d;
  logic                             out_vld_q;
  logic [htwd_pkg::SymW-1:0]        out_sym_q;
  logic                             out_last_q;

  htwd_pkg::node_t                  cur;
  logic [htwd_pkg::NodeIdxW-1:0]    child;
  logic                             out_free;
  logic                             rd_en, wr_en, wr_ok, rd_ok;
  logic [htwd_pkg::NodeIdxW-1:0]    rd_idx;
  logic                             push;
  logic [htwd_pkg::SymW-1:0]        push_sym;
  logic                             push_last;

  // an index past the table reads as a blank inner node
  assign cur      = rd_ok_q ? rd_data_q : '0;
  assign child    = byte_q[htwd_pkg::ByteW-1] ? cur.right : cur.left;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign wr_ok    = 32'(q_item_i.idx) < 32'(htwd_pkg::MaxNodes);
  assign rd_ok    = 32'(rd_idx) < 32'(htwd_pkg::MaxNodes);

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    byte_d     = byte_q;
    bits_d     = bits_q;
    pend_vld_d = pend_vld_q;
    pend_sym_d = pend_sym_q;
    q_pop_o    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_idx     = pos_q;
    push       = 1'b0;
    push_sym   = pend_sym_q;
    push_last  = 1'b0;
    unique case (state_q)
      htwd_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.kind)
            htwd_pkg::OP_WRITE: begin
              wr_en = 1'b1;
            end
            htwd_pkg::OP_RESTART: begin
              pos_d = root_index_i;
            end
            htwd_pkg::OP_DECODE: begin
              rd_en   = 1'b1;
              rd_idx  = pos_q;
              byte_d  = q_item_i.data;
              bits_d  = htwd_pkg::BitCntW'(htwd_pkg::BitsPerByte);
              state_d = htwd_pkg::ST_STEP;
            end
            default: ;
          endcase
        end
      end
      htwd_pkg::ST_STEP: begin
        // current node in the read register: take one bit
        rd_en   = 1'b1;
        rd_idx  = child;
        pos_d   = child;
        byte_d  = byte_q << 1;
        bits_d  = bits_q - 1'b1;
        state_d = htwd_pkg::ST_CHECK;
      end
      htwd_pkg::ST_CHECK: begin
        if (cur.leaf) begin
          if (!pend_vld_q || out_free) begin
            push       = pend_vld_q;
            pend_vld_d = 1'b1;
            pend_sym_d = cur.sym;
            pos_d      = root_index_i;
            if (bits_q == '0) begin
              state_d = htwd_pkg::ST_FLUSH;
            end else begin
              rd_en   = 1'b1;
              rd_idx  = root_index_i;
              state_d = htwd_pkg::ST_STEP;
            end
          end
        end else if (bits_q == '0) begin
          state_d = htwd_pkg::ST_FLUSH;
        end else begin
          rd_en   = 1'b1;
          rd_idx  = child;
          pos_d   = child;
          byte_d  = byte_q << 1;
          bits_d  = bits_q - 1'b1;
        end
      end
      htwd_pkg::ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = htwd_pkg::ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = htwd_pkg::ST_IDLE;
        end
      end
      default: state_d = htwd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= htwd_pkg::ST_IDLE;
      pos_q      <= '0;
      bits_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      bits_q     <= bits_d;
      pend_vld_q <= pend_vld_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    pend_sym_q <= pend_sym_d;
    if (push) begin
      out_sym_q  <= push_sym;
      out_last_q <= push_last;
    end
  end

  // node table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_ok) begin
      mem[htwd_pkg::MemAddrW'(q_item_i.idx)] <= q_item_i.node;
    end
    if (rd_en) begin
      rd_data_q <= mem[htwd_pkg::MemAddrW'(rd_idx)];
      rd_ok_q   <= rd_ok;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_sym_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ===== src/huffman_tree_walk_decoder_core.sv =====
// Top level of the Huffman tree-walk decoder: front end, item queue, walker.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  s_axis   | in        | tvalid / tready      | tuser: operation; tdata: node fields, byte
//  m_axis   | out       | tvalid / tready      | tdata: symbol; tlast: last_of_byte
//  cfg      | in        | cfg_we_i             | cfg_wdata_i: root_index
//
// A write-node or restart item is handled by the walker in IDLE. A decode byte walks
// the node table bit by bit through the STEP and CHECK states, each bit being one
// dependent read of the node table; output back-pressure can stall the walk at a
// leaf and in FLUSH.
// The front end keeps accepting into a four-entry queue while the walker is busy, until it is full.
// Reset clears walk position, root, queue and output; the node table is not cleared
// and holds rubbish until written.
// Each symbol is held back in a pending register so that tlast can mark the final one of a byte.
`default_nettype none

module huffman_tree_walk_decoder_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // [1:0] operation
  input  wire logic [htwd_pkg::OpW-1:0]      s_axis_tuser_i,
  // [8:0] node_index, [9] node_is_leaf, [18:10] left_child, [27:19] right_child,
  // [35:28] leaf_symbol, [43:36] data_byte, [47:44] zero
  input  wire logic [htwd_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] symbol
  output logic [htwd_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [htwd_pkg::NodeIdxW-1:0] cfg_wdata_i
);

  logic [htwd_pkg::NodeIdxW-1:0] root_q;
  logic                          q_push, q_ready, q_pop, q_valid;
  htwd_pkg::item_t               front_item, queue_item;

  // root only steers the walk at the next leaf or restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  htwd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_item_o        (front_item)
  );

  htwd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  htwd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (queue_item),
    .q_pop_o         (q_pop),
    .root_index_i    (root_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== src/htwd_checker.sv =====
// Port-level checks for the decoder core, bound to the top level.
`default_nettype none

module htwd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready_o,
  input wire logic [htwd_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                          m_axis_tlast_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid after reset");

  // reset empties the item queue, so the slave side is open
  a_rst_in: assert property (@(posedge clk_i) !rst_ni |=> s_axis_tready_o)
    else $error("slave not ready after reset");

endmodule

bind huffman_tree_walk_decoder_core htwd_checker u_htwd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the Huffman tree-walk decoder core.
`timescale 1ns / 1ps

module tb;
  import htwd_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;  // spare operation code, ignored by the core
  localparam int ItemTarget  = 320;            // items to send, directed and random together
  localparam int IdleCycles  = 120;            // lets five queued decodes drain, plus margin
  localparam int CycleLimit  = 1000000;
  localparam int MaxReports  = 100;
  localparam int ByModel     = -1;             // row is checked against the predictor

  typedef enum bit {ROW_ITEM, ROW_ROOT} row_kind_e;

  typedef struct packed {
    logic [OpW-1:0]      op;
    logic [NodeIdxW-1:0] idx;
    node_t               node;
    logic [ByteW-1:0]    data;
  } decoder_item_t;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            last;
  } sym_beat_t;

  // root rows carry the new root in the index column
  typedef struct packed {
    row_kind_e     kind;
    decoder_item_t it;
    bit            typed;
    logic [3:0]    n_exp;
    logic [SymW-1:0] exp_sym;
  } directed_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic [OpW-1:0]      s_axis_tuser_i  = '0;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [NodeIdxW-1:0] cfg_wdata_i     = '0;

  // predictor state
  node_t               node_mirror  [0:MaxNodes-1];
  bit                  node_written [0:MaxNodes-1];
  logic [NodeIdxW-1:0] written_nodes[$];
  logic [NodeIdxW-1:0] walk_pos = '0;
  logic [NodeIdxW-1:0] root_reg = '0;

  sym_beat_t     expected_symbols[$];
  directed_row_t directed_rows[$];
  sym_beat_t     got_beat;
  int            mismatches  = 0;
  int            items_sent  = 0;
  int            burst_left  = 0;
  int            cycle_count = 0;
  logic [15:0]   ready_pattern = 16'hFFFF;
  int            pattern_age   = 0;

  huffman_tree_walk_decoder_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    // cap the printout, keep counting
    if (mismatches < MaxReports) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Apply one item to the mirrored state; queue the symbols it decodes when keep is set.
  // The newest symbol is held back so that the final one of a byte can take the last flag.
  function automatic void advance_walk(input decoder_item_t it, input bit keep);
    node_t     cur;
    node_t     nxt;
    sym_beat_t held;
    bit        have_held;
    int        b;
    have_held = 1'b0;
    held      = '0;
    case (it.op)
      OP_WRITE: begin
        if (!node_written[it.idx]) written_nodes.push_back(it.idx);
        node_written[it.idx] = 1'b1;
        node_mirror[it.idx]  = it.node;
      end
      OP_RESTART: walk_pos = root_reg;
      OP_DECODE: begin
        for (b = ByteW - 1; b >= 0; b--) begin
          cur      = node_mirror[walk_pos];
          walk_pos = it.data[b] ? cur.right : cur.left;
          nxt      = node_mirror[walk_pos];
          if (nxt.leaf) begin
            if (have_held && keep) expected_symbols.push_back(held);
            held.sym  = nxt.sym;
            held.last = 1'b0;
            have_held = 1'b1;
            walk_pos  = root_reg;
          end
        end
        if (have_held && keep) begin
          held.last = 1'b1;
          expected_symbols.push_back(held);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic decoder_item_t random_item(input logic [OpW-1:0] op);
    decoder_item_t it;
    it.op         = op;
    it.idx        = NodeIdxW'($urandom_range(0, MaxNodes - 1));
    it.node.leaf  = 1'($urandom_range(0, 1));
    it.node.left  = NodeIdxW'($urandom_range(0, MaxNodes - 1));
    it.node.right = NodeIdxW'($urandom_range(0, MaxNodes - 1));
    it.node.sym   = SymW'($urandom_range(0, 255));
    it.data       = ByteW'($urandom_range(0, 255));
    return it;
  endfunction

  // Children always point at written entries, so every walk stays inside written nodes.
  function automatic logic [NodeIdxW-1:0] pick_written();
    return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [OpW-1:0] op,
                                  input int idx, input bit leaf, input int left,
                                  input int right, input int sym, input int data,
                                  input int n_exp, input int exp_sym);
    directed_row_t r;
    r.kind          = kind;
    r.it.op         = op;
    r.it.idx        = NodeIdxW'(idx);
    r.it.node.leaf  = leaf;
    r.it.node.left  = NodeIdxW'(left);
    r.it.node.right = NodeIdxW'(right);
    r.it.node.sym   = SymW'(sym);
    r.it.data       = ByteW'(data);
    r.typed         = (n_exp != ByModel);
    r.n_exp         = (n_exp == ByModel) ? 4'd0 : 4'(n_exp);
    r.exp_sym       = SymW'(exp_sym);
    directed_rows.push_back(r);
  endfunction

  // Send one beat in bursts with random gaps, then predict what it decodes.
  task automatic send(input decoder_item_t it, input bit typed, input int n_exp,
                      input logic [SymW-1:0] exp_sym);
    int k;
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tuser_i  <= it.op;
    // zero pad, byte, symbol, right, left, leaf flag, index
    s_axis_tdata_i  <= {4'b0, it.data, it.node.sym, it.node.right, it.node.left,
                        it.node.leaf, it.idx};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (it.op != OpUnused) items_sent++;
    advance_walk(it, !typed);
    if (typed)
      for (k = 0; k < n_exp; k++) expected_symbols.push_back({exp_sym, k == n_exp - 1});
  endtask

  // Drop valid, wait for every expected symbol, then let queued items drain.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [NodeIdxW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    root_reg = value;
  endtask

  // Receiver: rotate a ready pattern, reload it now and then.
  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'($urandom);
        2:       ready_pattern <= 16'($urandom | $urandom);
        default: ready_pattern <= 16'($urandom & $urandom);
      endcase
      pattern_age <= $urandom_range(16, 64);
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_age   <= pattern_age - 1;
    end
    m_axis_tready_i <= ready_pattern[0];
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_symbols.size() == 0) begin
        report_mismatch($sformatf("symbol %02h with none expected", m_axis_tdata_o));
      end else begin
        got_beat = expected_symbols.pop_front();
        if (m_axis_tdata_o !== got_beat.sym)
          report_mismatch($sformatf("symbol %02h, expected %02h", m_axis_tdata_o,
                                    got_beat.sym));
        if (m_axis_tlast_o !== got_beat.last)
          report_mismatch($sformatf("tlast %b, expected %b on symbol %02h", m_axis_tlast_o,
                                    got_beat.last, got_beat.sym));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL huffman_tree_walk_decoder_core");
      $finish;
    end
  end

  initial begin
    directed_row_t       row;
    decoder_item_t       it;
    logic [NodeIdxW-1:0] slots[$];
    logic [NodeIdxW-1:0] open_roots[$];
    bit                  taken[0:MaxNodes-1];
    int                  n_leaves;
    int                  n_nodes;
    int                  n_bytes;
    int                  k;
    int                  pick;
    int                  cand;

    for (k = 0; k < MaxNodes; k++) begin
      node_written[k] = 1'b0;
      node_mirror[k]  = '0;
      taken[k]        = 1'b0;
    end

    // One-bit codes at root 0: left gives 00, right gives FF.
    add_row(ROW_ITEM, OP_WRITE,   1,   1, 1,   1,   8'h00, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE,   2,   1, 2,   2,   8'hFF, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE,   0,   0, 1,   2,   8'h00, 0, 0, 0);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'h00, 8, 8'h00);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'hFF, 8, 8'hFF);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'hA5, ByModel, 0);
    // spare operation with every field at its top: ignored
    add_row(ROW_ITEM, OpUnused,   511, 1, 511, 511, 255, 255, 0, 0);
    // Two-bit tree at the top of the table; a 1 bit loops on the root.
    add_row(ROW_ITEM, OP_WRITE,   508, 1, 0,   0,   8'h01, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE,   509, 1, 0,   0,   8'hFE, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE,   510, 0, 508, 509, 8'h00, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE,   511, 0, 510, 511, 8'hFF, 0, 0, 0);
    // move the root while the walk still sits on the old one
    add_row(ROW_ROOT, OpUnused,   511, 0, 0,   0,   0, 0, 0, 0);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'h00, ByModel, 0);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'h7F, ByModel, 0);
    // byte that reaches no leaf
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'hFF, 0, 0);
    add_row(ROW_ITEM, OP_RESTART, 0,   0, 0,   0,   0, 0, 0, 0);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'h00, 4, 8'h01);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'h55, 4, 8'hFE);
    add_row(ROW_ROOT, OpUnused,   0,   0, 0,   0,   0, 0, 0, 0);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'hC3, ByModel, 0);
    add_row(ROW_ITEM, OP_RESTART, 0,   0, 0,   0,   0, 0, 0, 0);
    add_row(ROW_ITEM, OP_DECODE,  0,   0, 0,   0,   0, 8'h96, ByModel, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if (row.kind == ROW_ROOT) begin
        settle();
        write_root(row.it.idx);
      end else begin
        send(row.it, row.typed, row.n_exp, row.exp_sym);
      end
    end

    // Random phases: place a fresh tree, point the root at it, then feed bytes.
    while (items_sent < ItemTarget) begin
      n_leaves = $urandom_range(2, 10);
      n_nodes  = 2 * n_leaves - 1;
      for (k = 0; k < slots.size(); k++) taken[slots[k]] = 1'b0;
      slots.delete();
      open_roots.delete();
      for (k = 0; k < n_nodes; k++) begin
        do pick = $urandom_range(0, MaxNodes - 1); while (taken[pick]);
        taken[pick] = 1'b1;
        slots.push_back(NodeIdxW'(pick));
      end
      // now and then put the root at either end of the table
      if ($urandom_range(0, 5) == 0) begin
        cand = $urandom_range(0, 1) ? MaxNodes - 1 : 0;
        if (!taken[cand]) begin
          taken[slots[n_nodes-1]] = 1'b0;
          slots[n_nodes-1]        = NodeIdxW'(cand);
          taken[cand]             = 1'b1;
        end
      end

      // the root is written before any leaf or restart can reach it
      settle();
      write_root(slots[n_nodes-1]);

      // leaves first, then join subtrees pairwise bottom-up
      for (k = 0; k < n_leaves; k++) begin
        it            = random_item(OP_WRITE);
        it.idx        = slots[k];
        it.node.leaf  = 1'b1;
        it.node.left  = pick_written();
        it.node.right = pick_written();
        send(it, 1'b0, 0, '0);
        open_roots.push_back(slots[k]);
      end
      for (k = n_leaves; k < n_nodes; k++) begin
        it           = random_item(OP_WRITE);
        it.idx       = slots[k];
        it.node.leaf = 1'b0;
        pick         = $urandom_range(0, open_roots.size() - 1);
        it.node.left = open_roots[pick];
        open_roots.delete(pick);
        pick          = $urandom_range(0, open_roots.size() - 1);
        it.node.right = open_roots[pick];
        open_roots.delete(pick);
        send(it, 1'b0, 0, '0);
        open_roots.push_back(slots[k]);
      end

      // mostly restart; otherwise the walk carries on from where the last phase left it
      if ($urandom_range(0, 4) != 0) send(random_item(OP_RESTART), 1'b0, 0, '0);

      n_bytes = $urandom_range(4, 16);
      repeat (n_bytes) begin
        case ($urandom_range(0, 9))
          0: begin
            it            = random_item(OP_WRITE);
            it.node.left  = pick_written();
            it.node.right = pick_written();
          end
          1:       it = random_item(OP_RESTART);
          2:       it = random_item(OpUnused);
          default: it = random_item(OP_DECODE);
        endcase
        send(it, 1'b0, 0, '0);
      end
    end

    // drain the last symbols and give the core time to show anything spurious
    settle();
    if (mismatches == 0) begin
      $display("PASS huffman_tree_walk_decoder_core");
    end else begin
      $display("FAIL huffman_tree_walk_decoder_core");
    end
    $finish;
  end

endmodule

// ===== huffman_tree_walk_decoder_core.f =====
src/htwd_pkg.sv
src/htwd_front.sv
src/htwd_queue.sv
src/htwd_back.sv
src/huffman_tree_walk_decoder_core.sv
src/htwd_checker.sv
test/tb.sv
